>>> rtl/core/pds_pkg.sv
// pds_pkg: shared constants, types and microcode store for the pll divider search
`timescale 1ns / 1ps

package pds_pkg;

	// divider datapath width, covers the largest vco value
	localparam int unsigned DIV_W = 29;

	// frequency limits in hertz
	localparam logic [25:0] INTERNAL_CLK = 26'd16000000;
	localparam logic [28:0] REF_HIGH     = 29'd16000000;
	localparam logic [28:0] REF_LOW      = 29'd4000000;
	localparam logic [28:0] USB_CLOCK    = 29'd48000000;
	localparam logic [28:0] VCO_LOW      = 29'd64000000;
	localparam logic [28:0] VCO_HIGH     = 29'd344000000;
	localparam logic [26:0] TARGET_HIGH  = 27'd80000000;

	// divider and multiplier limits
	localparam logic [6:0] MUL_LOW    = 7'd8;
	localparam logic [6:0] MUL_HIGH   = 7'd86;
	localparam logic [3:0] DIVM_LIMIT = 4'd15;

	// source codes
	localparam logic [1:0] SRC_NONE = 2'd0;
	localparam logic [1:0] SRC_EXT  = 2'd3;

	typedef enum logic [1:0] {
		ST_FOUND    = 2'd0,
		ST_DISABLED = 2'd1,
		ST_INVALID  = 2'd2,
		ST_NOMATCH  = 2'd3
	} status_t;

	// datapath operations, one per microcode step
	typedef enum logic [3:0] {
		ACT_NONE       = 4'd0,
		ACT_LD_IN      = 4'd1,
		ACT_SET_MRANGE = 4'd2,
		ACT_DIV_REF    = 4'd3,
		ACT_LD_REF     = 4'd4,
		ACT_N_INC      = 4'd5,
		ACT_M_INC      = 4'd6,
		ACT_NOMATCH    = 4'd7,
		ACT_DIV_QF     = 4'd8,
		ACT_LD_QF      = 4'd9,
		ACT_LD_OUT     = 4'd10
	} act_t;

	// jump conditions
	typedef enum logic [3:0] {
		C_ALWAYS   = 4'd0,
		C_IN_VALID = 4'd1,
		C_EARLY    = 4'd2,
		C_DIV_BUSY = 4'd3,
		C_M_OVER   = 4'd4,
		C_REF_BAD  = 4'd5,
		C_N_STOP   = 4'd6,
		C_HIT      = 4'd7,
		C_OUT_BUSY = 4'd8
	} cond_t;

	typedef logic [4:0] upc_t;

	// microcode labels
	localparam upc_t P_IDLE    = 5'd0;
	localparam upc_t P_CHK     = 5'd1;
	localparam upc_t P_MRANGE  = 5'd2;
	localparam upc_t P_MLOOP   = 5'd3;
	localparam upc_t P_REF     = 5'd4;
	localparam upc_t P_REF_W   = 5'd5;
	localparam upc_t P_REF_LD  = 5'd6;
	localparam upc_t P_REF_CHK = 5'd7;
	localparam upc_t P_NLOOP   = 5'd8;
	localparam upc_t P_NHIT    = 5'd9;
	localparam upc_t P_NNEXT   = 5'd10;
	localparam upc_t P_MNEXT   = 5'd11;
	localparam upc_t P_NOMATCH = 5'd12;
	localparam upc_t P_FOUND   = 5'd13;
	localparam upc_t P_QF_W    = 5'd14;
	localparam upc_t P_QF_LD   = 5'd15;
	localparam upc_t P_OUT     = 5'd16;
	localparam upc_t P_RET     = 5'd17;

	// control word: jump to target when the selected flag xor inv is set
	typedef struct packed {
		act_t  act;
		cond_t cond;
		logic  inv;
		upc_t  target;
	} uword_t;

	// status flags from the datapath to the sequencer
	typedef struct packed {
		logic in_valid;
		logic early;
		logic div_busy;
		logic m_over;
		logic ref_bad;
		logic n_stop;
		logic hit;
		logic out_busy;
	} flags_t;

	function automatic uword_t uw(input act_t act, input cond_t cond, input logic inv,
			input upc_t target);
		uword_t w;
		w.act    = act;
		w.cond   = cond;
		w.inv    = inv;
		w.target = target;
		return w;
	endfunction

	// program store; a step with an inverted always condition falls through
	function automatic uword_t ucode(input upc_t pc);
		uword_t w;
		case (pc)
			P_IDLE:    w = uw(ACT_LD_IN,      C_IN_VALID, 1'b1, P_IDLE);
			P_CHK:     w = uw(ACT_NONE,       C_EARLY,    1'b0, P_OUT);
			P_MRANGE:  w = uw(ACT_SET_MRANGE, C_ALWAYS,   1'b1, P_IDLE);
			P_MLOOP:   w = uw(ACT_NONE,       C_M_OVER,   1'b0, P_NOMATCH);
			P_REF:     w = uw(ACT_DIV_REF,    C_ALWAYS,   1'b1, P_IDLE);
			P_REF_W:   w = uw(ACT_NONE,       C_DIV_BUSY, 1'b0, P_REF_W);
			P_REF_LD:  w = uw(ACT_LD_REF,     C_ALWAYS,   1'b1, P_IDLE);
			P_REF_CHK: w = uw(ACT_NONE,       C_REF_BAD,  1'b0, P_MNEXT);
			P_NLOOP:   w = uw(ACT_NONE,       C_N_STOP,   1'b0, P_MNEXT);
			P_NHIT:    w = uw(ACT_NONE,       C_HIT,      1'b0, P_FOUND);
			P_NNEXT:   w = uw(ACT_N_INC,      C_ALWAYS,   1'b0, P_NLOOP);
			P_MNEXT:   w = uw(ACT_M_INC,      C_ALWAYS,   1'b0, P_MLOOP);
			P_NOMATCH: w = uw(ACT_NOMATCH,    C_ALWAYS,   1'b0, P_OUT);
			P_FOUND:   w = uw(ACT_DIV_QF,     C_ALWAYS,   1'b1, P_IDLE);
			P_QF_W:    w = uw(ACT_NONE,       C_DIV_BUSY, 1'b0, P_QF_W);
			P_QF_LD:   w = uw(ACT_LD_QF,      C_ALWAYS,   1'b1, P_IDLE);
			P_OUT:     w = uw(ACT_LD_OUT,     C_OUT_BUSY, 1'b0, P_OUT);
			P_RET:     w = uw(ACT_NONE,       C_ALWAYS,   1'b0, P_IDLE);
			default:   w = uw(ACT_NONE,       C_ALWAYS,   1'b0, P_IDLE);
		endcase
		return w;
	endfunction

endpackage

>>> rtl/core/pds_divider.sv
// pds_divider: restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps

module pds_divider import pds_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DIV_W-1:0] num,
	input  logic [DIV_W-1:0] den,
	output logic             busy,
	output logic [DIV_W-1:0] quot
);

	localparam int unsigned CW = $clog2(DIV_W + 1);

	logic [CW-1:0]    cnt_q;
	logic [DIV_W-1:0] rem_q;
	logic [DIV_W-1:0] quo_q;
	logic [DIV_W-1:0] den_q;
	logic [DIV_W:0]   sh;
	logic [DIV_W+1:0] diff;
	logic             ge;

	// shift in next numerator bit and trial subtract
	assign sh   = {rem_q, quo_q[DIV_W-1]};
	assign diff = {1'b0, sh} - {2'b00, den_q};
	assign ge   = ~diff[DIV_W+1];
	assign busy = (cnt_q != '0);
	assign quot = quo_q;

	// bit counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CW'(DIV_W);
		end else if (busy) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// remainder and quotient
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (busy) begin
			rem_q <= ge ? diff[DIV_W-1:0] : sh[DIV_W-1:0];
			quo_q <= {quo_q[DIV_W-2:0], ge};
		end
	end

endmodule

>>> rtl/core/pds_datapath.sv
// pds_datapath: search registers, range checks, match compare and result register
`timescale 1ns / 1ps

module pds_datapath import pds_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  act_t        act,
	input  logic        in_valid,
	input  logic [1:0]  source,
	input  logic [25:0] ext_freq,
	input  logic [26:0] target_freq,
	input  logic        out_ready,
	output flags_t      flags,
	output logic        out_valid,
	output logic [1:0]  status,
	output logic [3:0]  in_div,
	output logic [6:0]  vco_mul,
	output logic [3:0]  out_div,
	output logic [2:0]  usb_div,
	output logic [28:0] q_clk_freq
);

	logic [25:0]      fin_q;
	logic [29:0]      lo_q [4];
	status_t          st_q;
	logic             early_q;
	logic [4:0]       m_q;
	logic [3:0]       mlast_q;
	logic [25:0]      ref_q;
	logic [6:0]       n_q;
	logic [28:0]      vco_q;
	logic [1:0]       ridx_q;
	logic [2:0]       q_q;
	logic [28:0]      qf_q;

	logic             out_valid_q;
	logic [1:0]       status_q;
	logic [3:0]       in_div_q;
	logic [6:0]       vco_mul_q;
	logic [3:0]       out_div_q;
	logic [2:0]       usb_div_q;
	logic [28:0]      q_clk_freq_q;

	status_t          early_st;
	logic             early_flag;
	logic [4:0]       mfirst_c;
	logic [3:0]       mlast_c;
	logic [2:0]       q_c;
	logic             div_start;
	logic [DIV_W-1:0] div_num;
	logic [DIV_W-1:0] div_den;
	logic             div_busy;
	logic [DIV_W-1:0] div_quot;
	logic [3:0]       hit_k;
	logic [1:0]       hit_idx;
	logic [30:0]      diff_k [4];
	logic             out_busy;
	logic             out_load;
	logic             found;

	pds_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.busy   (div_busy),
		.quot   (div_quot)
	);

	// request screening at accept
	always_comb begin
		early_st   = ST_FOUND;
		early_flag = 1'b0;
		if (target_freq > TARGET_HIGH) begin
			early_st   = ST_INVALID;
			early_flag = 1'b1;
		end else if (target_freq == '0 || source == SRC_NONE) begin
			early_st   = ST_DISABLED;
			early_flag = 1'b1;
		end else if (source == SRC_EXT && ext_freq == '0) begin
			early_st   = ST_INVALID;
			early_flag = 1'b1;
		end
	end

	// divisions by fixed frequencies as compares against their multiples
	always_comb begin
		mfirst_c = 5'd1;
		for (int k = 2; k <= 4; k++) begin
			if ({3'b000, fin_q} >= 29'(k) * REF_HIGH) begin
				mfirst_c = 5'(k);
			end
		end
		mlast_c = 4'd0;
		for (int k = 1; k <= int'(DIVM_LIMIT); k++) begin
			if ({3'b000, fin_q} >= 29'(k) * REF_LOW) begin
				mlast_c = 4'(k);
			end
		end
		q_c = 3'd0;
		for (int k = 1; k <= 7; k++) begin
			if (vco_q >= 29'(k) * USB_CLOCK) begin
				q_c = 3'(k);
			end
		end
	end

	// divider operand select
	always_comb begin
		div_start = 1'b0;
		div_num   = DIV_W'(fin_q);
		div_den   = DIV_W'(m_q);
		case (act)
			ACT_DIV_REF: begin
				div_start = 1'b1;
			end
			ACT_DIV_QF: begin
				div_start = 1'b1;
				div_num   = vco_q;
				div_den   = DIV_W'(q_c);
			end
			default: begin
				div_start = 1'b0;
			end
		endcase
	end

	// vco / r == target for r = 2, 4, 6, 8 in parallel
	always_comb begin
		for (int k = 0; k < 4; k++) begin
			diff_k[k] = {2'b00, vco_q} - {1'b0, lo_q[k]};
			hit_k[k]  = ~diff_k[k][30] && (diff_k[k][29:0] < 30'(2 * (k + 1)));
		end
		if (hit_k[0]) begin
			hit_idx = 2'd0;
		end else if (hit_k[1]) begin
			hit_idx = 2'd1;
		end else if (hit_k[2]) begin
			hit_idx = 2'd2;
		end else begin
			hit_idx = 2'd3;
		end
	end

	assign out_busy = out_valid_q && !out_ready;
	assign out_load = (act == ACT_LD_OUT) && !out_busy;
	assign found    = (st_q == ST_FOUND);

	// flags for the sequencer
	always_comb begin
		flags.in_valid = in_valid;
		flags.early    = early_q;
		flags.div_busy = div_busy;
		flags.m_over   = (m_q > {1'b0, mlast_q});
		flags.ref_bad  = ({3'b000, ref_q} < REF_LOW) || ({3'b000, ref_q} > REF_HIGH);
		flags.n_stop   = (n_q > MUL_HIGH) || (vco_q > VCO_HIGH);
		flags.hit      = !(vco_q < VCO_LOW) && (hit_k != '0);
		flags.out_busy = out_busy;
	end

	// search registers
	always_ff @(posedge clk) begin
		case (act)
			ACT_LD_IN: begin
				if (in_valid) begin
					fin_q    <= (source == SRC_EXT) ? ext_freq : INTERNAL_CLK;
					lo_q[0]  <= 30'({target_freq, 1'b0});
					lo_q[1]  <= 30'({target_freq, 2'b00});
					lo_q[2]  <= 30'({target_freq, 2'b00}) + 30'({target_freq, 1'b0});
					lo_q[3]  <= 30'({target_freq, 3'b000});
					st_q     <= early_st;
					early_q  <= early_flag;
				end
			end
			ACT_SET_MRANGE: begin
				m_q     <= mfirst_c;
				mlast_q <= mlast_c;
			end
			ACT_LD_REF: begin
				ref_q <= div_quot[25:0];
				vco_q <= {div_quot[25:0], 3'b000};
				n_q   <= MUL_LOW;
			end
			ACT_N_INC: begin
				n_q   <= n_q + 1'b1;
				vco_q <= vco_q + 29'(ref_q);
			end
			ACT_M_INC: begin
				m_q <= m_q + 1'b1;
			end
			ACT_NOMATCH: begin
				st_q <= ST_NOMATCH;
			end
			ACT_DIV_QF: begin
				ridx_q <= hit_idx;
				q_q    <= q_c;
			end
			ACT_LD_QF: begin
				qf_q <= (q_q == '0) ? '0 : div_quot;
			end
			default: begin
			end
		endcase
	end

	// result word valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result word payload; status always loaded, divider fields zero unless found
	always_ff @(posedge clk) begin
		if (out_load) begin
			status_q     <= st_q;
			in_div_q     <= found ? m_q[3:0] : 4'd0;
			vco_mul_q    <= found ? n_q : 7'd0;
			out_div_q    <= found ? ({1'b0, ridx_q, 1'b0} + 4'd2) : 4'd0;
			usb_div_q    <= found ? q_q : 3'd0;
			q_clk_freq_q <= found ? qf_q : 29'd0;
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign in_div     = in_div_q;
	assign vco_mul    = vco_mul_q;
	assign out_div    = out_div_q;
	assign usb_div    = usb_div_q;
	assign q_clk_freq = q_clk_freq_q;

endmodule

>>> rtl/core/pds_sequencer.sv
// pds_sequencer: step counter over the microcode store with conditional jumps
`timescale 1ns / 1ps

module pds_sequencer import pds_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  flags_t flags,
	output act_t   act
);

	upc_t   pc_q;
	uword_t word;
	logic   sel;
	logic   take;

	assign word = ucode(pc_q);
	assign act  = word.act;

	// condition select
	always_comb begin
		case (word.cond)
			C_ALWAYS:   sel = 1'b1;
			C_IN_VALID: sel = flags.in_valid;
			C_EARLY:    sel = flags.early;
			C_DIV_BUSY: sel = flags.div_busy;
			C_M_OVER:   sel = flags.m_over;
			C_REF_BAD:  sel = flags.ref_bad;
			C_N_STOP:   sel = flags.n_stop;
			C_HIT:      sel = flags.hit;
			C_OUT_BUSY: sel = flags.out_busy;
			default:    sel = 1'b1;
		endcase
	end

	assign take = sel ^ word.inv;

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= P_IDLE;
		end else if (take) begin
			pc_q <= word.target;
		end else begin
			pc_q <= pc_q + 1'b1;
		end
	end

endmodule

>>> rtl/core/pll_divider_search_unit.sv
// pll divider search: one request in, one divider setting result out
// Each input divider takes one pass of the shared serial divider, then a
// multiplier loop; a found triple adds one more divider pass.
// Throughput: one request at a time; the next is taken once the result is in
// the output register. Reset puts the sequencer at idle and drops out_valid.
`timescale 1ns / 1ps

module pll_divider_search_unit import pds_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  source,
	input  logic [25:0] ext_freq,
	input  logic [26:0] target_freq,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic [3:0]  in_div,
	output logic [6:0]  vco_mul,
	output logic [3:0]  out_div,
	output logic [2:0]  usb_div,
	output logic [28:0] q_clk_freq
);

	act_t   act;
	flags_t flags;

	// request word taken only in the idle step
	assign in_ready = (act == ACT_LD_IN);

	pds_sequencer u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.flags  (flags),
		.act    (act)
	);

	pds_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.act         (act),
		.in_valid    (in_valid),
		.source      (source),
		.ext_freq    (ext_freq),
		.target_freq (target_freq),
		.out_ready   (out_ready),
		.flags       (flags),
		.out_valid   (out_valid),
		.status      (status),
		.in_div      (in_div),
		.vco_mul     (vco_mul),
		.out_div     (out_div),
		.usb_div     (usb_div),
		.q_clk_freq  (q_clk_freq)
	);

endmodule
